/* design/ukt_pkg.sv */
// Package for the unique-key table: sizes, status codes and the record and
// control types shared by the cell row and the top level.
// No dependencies.
package ukt_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths fixed by the stream format
    localparam int KEY_W    = 32;
    localparam int AGE_W    = 8;
    localparam int SCORE_W  = 9;
    localparam int STATUS_W = 3;
    localparam int ECOUNT_W = 7;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;

    // Operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

    // Full-table count value
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // One stored record
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [AGE_W-1:0]        age;
        logic [SCORE_W-1:0]      score;
    } rec_t;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic             insert_en;
        logic             delete_en;
        logic [CNT_W-1:0] count;
        rec_t             rec;
    } ctl_t;

endpackage

/* design/ukt_cell.sv */
// One cell of the table row: holds a record, compares its key, and on a
// delete takes the record of its upper neighbor. Depends on ukt_pkg.
module ukt_cell (
    input  logic                      clk,
    input  ukt_pkg::ctl_t             ctl,
    input  logic [ukt_pkg::IDX_W-1:0] idx,       // position of this cell
    input  logic                      seen_in,   // a match at a lower cell
    output logic                      seen_out,  // a match here or below
    input  ukt_pkg::rec_t             upper_rec, // record of cell idx+1
    output ukt_pkg::rec_t             rec
);

    ukt_pkg::rec_t           rec_reg;
    ukt_pkg::rec_t           rec_next;
    logic [ukt_pkg::CNT_W-1:0] pos;
    logic                    occupied;
    logic                    hit;

    // Match against the broadcast key, only within the filled part
    assign pos      = ukt_pkg::CNT_W'(idx);
    assign occupied = pos < ctl.count;
    assign hit      = occupied && (rec_reg.key == ctl.rec.key);
    assign seen_out = seen_in | hit;
    assign rec      = rec_reg;

    // Delete shifts down from the match upward; insert fills the slot at the count
    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.delete_en && seen_out)
        begin
            rec_next = upper_rec;
        end
        else if (ctl.insert_en && (pos == ctl.count))
        begin
            rec_next = ctl.rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

/* design/unique_key_table_insert_delete_unit.sv */
// Each result beat appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle; a new beat is taken while the result
// register is empty or being drained in the same cycle.
// The search across the row of cells is combinational, and the shift is written as the beat is accepted.
// Reset clears the record count and the result valid flag; record contents
// are not cleared, and only entries below the count are ever compared.
module unique_key_table_insert_delete_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ukt_pkg::S_DATA_W-1:0]   s_tdata,  // key[31:0], age[39:32], score[48:40]
    input  logic                           s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ukt_pkg::M_DATA_W-1:0]   m_tdata   // status[2:0], entry_count[9:3]
);

    localparam int CAP = ukt_pkg::CAPACITY;

    logic [ukt_pkg::CNT_W-1:0]    count_reg;
    logic [ukt_pkg::CNT_W-1:0]    count_next;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [ukt_pkg::STATUS_W-1:0] status_reg;
    logic [ukt_pkg::STATUS_W-1:0] status_next;
    logic [ukt_pkg::ECOUNT_W-1:0] ecount_reg;
    logic [ukt_pkg::ECOUNT_W-1:0] ecount_next;

    logic                         accept;
    logic                         full;
    logic                         found;
    ukt_pkg::rec_t                in_rec;
    ukt_pkg::ctl_t                ctl;
    logic [CAP:0]                 seen;
    ukt_pkg::rec_t                recs [CAP];
    ukt_pkg::rec_t                uppers [CAP];

    // Input beat unpacking
    assign in_rec.key   = s_tdata[31:0];
    assign in_rec.age   = s_tdata[39:32];
    assign in_rec.score = s_tdata[48:40];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == ukt_pkg::CNT_FULL);

    // Control broadcast to the row
    assign ctl.insert_en = accept && (s_tuser == ukt_pkg::KIND_INSERT) && !full && !found;
    assign ctl.delete_en = accept && (s_tuser == ukt_pkg::KIND_DELETE) && found;
    assign ctl.count     = count_reg;
    assign ctl.rec       = in_rec;

    // Row of cells, match flag rippling upward
    assign seen[0] = 1'b0;
    assign found   = seen[CAP];

    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        if (g == CAP - 1)
        begin : g_top
            assign uppers[g] = '0;
        end
        else
        begin : g_mid
            assign uppers[g] = recs[g+1];
        end

        ukt_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .idx       (ukt_pkg::IDX_W'(g)),
            .seen_in   (seen[g]),
            .seen_out  (seen[g+1]),
            .upper_rec (uppers[g]),
            .rec       (recs[g])
        );
    end

    // Status and count update
    always_comb
    begin
        count_next    = count_reg;
        status_next   = status_reg;
        ecount_next   = ecount_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
            unique case (s_tuser)
                ukt_pkg::KIND_INSERT:
                begin
                    priority if (full)
                    begin
                        status_next = ukt_pkg::ST_FULL;
                    end
                    else if (found)
                    begin
                        status_next = ukt_pkg::ST_DUPLICATE;
                    end
                    else
                    begin
                        status_next = ukt_pkg::ST_INSERTED;
                        count_next  = count_reg + 1'b1;
                    end
                end
                ukt_pkg::KIND_DELETE:
                begin
                    if (found)
                    begin
                        status_next = ukt_pkg::ST_DELETED;
                        count_next  = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = ukt_pkg::ST_NOTFOUND;
                    end
                end
                default:
                begin
                    status_next = ukt_pkg::ST_NOTFOUND;
                end
            endcase
            ecount_next = ukt_pkg::ECOUNT_W'(count_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ecount_reg <= ecount_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, ecount_reg, status_reg};

endmodule
